// ===== src/assert_macros.svh =====
// Shared assertion macros for the block's checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/fpdc_pkg.sv =====
`default_nettype none
package fpdc_pkg;

    localparam int NUM_SETS = 5;
    localparam int LANES    = 2 * NUM_SETS;
    localparam int RULES    = NUM_SETS * NUM_SETS;
    localparam int MU_BITS  = 16;
    localparam int Q_BITS   = 17;

    localparam logic [14:0] SPACING_RESET    = 15'd5120;
    localparam logic [14:0] HALF_WIDTH_RESET = 15'd5120;
    localparam logic [16:0] SAT_POS          = 17'd32767;
    localparam logic [16:0] SAT_NEG          = 17'd32768;

    typedef enum logic [1:0] {
        REG_CENTRE     = 2'd0,
        REG_SPACING    = 2'd1,
        REG_HALF_WIDTH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] error_value;
        logic signed [15:0] error_change;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] correction;
        logic               no_rule_fired;
    } result_t;

    typedef struct packed {
        logic signed [15:0] centre;
        logic [14:0]        spacing;
        logic [14:0]        half_width;
    } cfg_t;

    // lanes 0..4: error sets, lanes 5..9: error-change sets
    typedef logic [LANES-1:0][MU_BITS-1:0] lane_vec_t;

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [19:0] den;
        logic [38:0] mag;
    } avg_t;

    function automatic logic signed [17:0] centre_of(input cfg_t cfg, input int k);
        logic signed [17:0] c;
        logic signed [17:0] s1;
        logic signed [17:0] s2;
        c  = {{2{cfg.centre[15]}}, cfg.centre};
        s1 = {3'b000, cfg.spacing};
        s2 = {2'b00, cfg.spacing, 1'b0};
        case (k)
            0:       return c - s2;
            1:       return c - s1;
            2:       return c;
            3:       return c + s1;
            default: return c + s2;
        endcase
    endfunction

    // output set chosen by rule (i, j)
    function automatic int sel_of(input int i, input int j);
        int s;
        s = NUM_SETS + 1 - i - j;
        if (s < 0)
            s = 0;
        if (s > NUM_SETS - 1)
            s = NUM_SETS - 1;
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== src/fpdc_fuzz.sv =====
`default_nettype none
module fpdc_fuzz (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire fpdc_pkg::cfg_t    cfg,
    input  wire logic              in_valid,
    input  wire fpdc_pkg::sample_t in_item,
    output logic                   out_valid,
    output fpdc_pkg::lane_vec_t    rest
);

    logic                           v1_reg;
    logic                           v2_reg;
    logic signed [fpdc_pkg::LANES-1:0][18:0] diff_reg;
    logic signed [fpdc_pkg::LANES-1:0][18:0] diff_next;
    fpdc_pkg::lane_vec_t            rest_reg;
    fpdc_pkg::lane_vec_t            rest_next;

    always_comb
    begin
        logic signed [17:0] c;
        logic signed [15:0] x;
        for (int l = 0; l < fpdc_pkg::LANES; l++)
        begin
            c = fpdc_pkg::centre_of(cfg, l % fpdc_pkg::NUM_SETS);
            x = (l < fpdc_pkg::NUM_SETS) ? in_item.error_value : in_item.error_change;
            diff_next[l] = $signed({{3{x[15]}}, x}) - $signed({c[17], c});
        end
    end

    // distance to centre, then the remainder the triangle leaves
    always_comb
    begin
        logic [18:0] d;
        for (int l = 0; l < fpdc_pkg::LANES; l++)
        begin
            d = diff_reg[l][18] ? 19'(-diff_reg[l]) : 19'(diff_reg[l]);
            if (d < {4'b0000, cfg.half_width})
                rest_next[l] = {1'b0, cfg.half_width - d[14:0]};
            else
                rest_next[l] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            rest_reg <= rest_next;
        end
    end

    assign out_valid = v2_reg;
    assign rest      = rest_reg;

endmodule
`default_nettype wire

// ===== src/fpdc_mdiv.sv =====
`default_nettype none
module fpdc_mdiv (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire fpdc_pkg::cfg_t      cfg,
    input  wire logic                in_valid,
    input  wire fpdc_pkg::lane_vec_t rest,
    output logic                     out_valid,
    output fpdc_pkg::lane_vec_t      mu
);

    logic                v_reg   [fpdc_pkg::MU_BITS];
    fpdc_pkg::lane_vec_t rem_reg [fpdc_pkg::MU_BITS];
    fpdc_pkg::lane_vec_t q_reg   [fpdc_pkg::MU_BITS];

    // one quotient bit per stage: q = rest * 2^15 / half_width
    for (genvar s = 0; s < fpdc_pkg::MU_BITS; s++)
    begin : g_step
        logic                v_in;
        fpdc_pkg::lane_vec_t rem_in;
        fpdc_pkg::lane_vec_t q_in;
        fpdc_pkg::lane_vec_t rem_n;
        fpdc_pkg::lane_vec_t q_n;

        if (s == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = rest;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign v_in   = v_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        always_comb
        begin
            logic [16:0] t;
            logic        ge;
            for (int l = 0; l < fpdc_pkg::LANES; l++)
            begin
                // first stage takes the integer bit (full weight at the centre)
                t        = (s == 0) ? {1'b0, rem_in[l]} : {rem_in[l], 1'b0};
                ge       = t >= {2'b00, cfg.half_width};
                rem_n[l] = ge ? 16'(t - {2'b00, cfg.half_width}) : t[15:0];
                q_n[l]   = {q_in[l][14:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_n;
                q_reg[s]   <= q_n;
            end
        end
    end

    assign out_valid = v_reg[fpdc_pkg::MU_BITS-1];
    // zero half width: no set has any weight
    assign mu = (cfg.half_width == '0) ? '0 : q_reg[fpdc_pkg::MU_BITS-1];

endmodule
`default_nettype wire

// ===== src/fpdc_rules.sv =====
`default_nettype none
module fpdc_rules (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire fpdc_pkg::cfg_t      cfg,
    input  wire logic                in_valid,
    input  wire fpdc_pkg::lane_vec_t mu,
    output logic                     out_valid,
    output fpdc_pkg::avg_t           avg
);

    logic [4:0] v_reg;

    logic [fpdc_pkg::RULES-1:0][fpdc_pkg::MU_BITS-1:0] min_reg,  min_next;
    logic [fpdc_pkg::NUM_SETS-1:0][17:0]        w_reg,    w_next;
    logic signed [fpdc_pkg::NUM_SETS-1:0][36:0] prod_reg, prod_next;
    logic [19:0]                                den3_reg, den3_next;
    logic signed [39:0]                         num_reg,  num_next;
    logic [19:0]                                den4_reg;
    fpdc_pkg::avg_t                             avg_reg,  avg_next;

    always_comb
    begin
        for (int i = 0; i < fpdc_pkg::NUM_SETS; i++)
            for (int j = 0; j < fpdc_pkg::NUM_SETS; j++)
                min_next[i*fpdc_pkg::NUM_SETS+j] =
                    (mu[i] < mu[fpdc_pkg::NUM_SETS+j]) ? mu[i] : mu[fpdc_pkg::NUM_SETS+j];
    end

    // fold rule weights by the output set they select
    always_comb
    begin
        for (int s = 0; s < fpdc_pkg::NUM_SETS; s++)
        begin
            w_next[s] = '0;
            for (int i = 0; i < fpdc_pkg::NUM_SETS; i++)
                for (int j = 0; j < fpdc_pkg::NUM_SETS; j++)
                    if (fpdc_pkg::sel_of(i, j) == s)
                        w_next[s] = w_next[s] + 18'(min_reg[i*fpdc_pkg::NUM_SETS+j]);
        end
    end

    always_comb
    begin
        den3_next = '0;
        for (int s = 0; s < fpdc_pkg::NUM_SETS; s++)
        begin
            prod_next[s] = $signed({1'b0, w_reg[s]}) * fpdc_pkg::centre_of(cfg, s);
            den3_next    = den3_next + 20'(w_reg[s]);
        end
    end

    always_comb
    begin
        num_next = '0;
        for (int s = 0; s < fpdc_pkg::NUM_SETS; s++)
            num_next = num_next + $signed({{3{prod_reg[s][36]}}, prod_reg[s]});
    end

    always_comb
    begin
        avg_next.neg  = num_reg[39];
        avg_next.zero = (den4_reg == '0);
        avg_next.den  = den4_reg;
        avg_next.mag  = num_reg[39] ? 39'(-num_reg) : num_reg[38:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            min_reg  <= min_next;
            w_reg    <= w_next;
            prod_reg <= prod_next;
            den3_reg <= den3_next;
            num_reg  <= num_next;
            den4_reg <= den3_reg;
            avg_reg  <= avg_next;
        end
    end

    assign out_valid = v_reg[4];
    assign avg       = avg_reg;

endmodule
`default_nettype wire

// ===== src/fpdc_adiv.sv =====
`default_nettype none
module fpdc_adiv (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire fpdc_pkg::avg_t   avg,
    output logic                  out_valid,
    output fpdc_pkg::result_t     result
);

    logic           v_reg   [fpdc_pkg::Q_BITS];
    fpdc_pkg::avg_t a_reg   [fpdc_pkg::Q_BITS];
    logic [19:0]    rem_reg [fpdc_pkg::Q_BITS];
    logic [16:0]    q_reg   [fpdc_pkg::Q_BITS];

    logic              vo_reg;
    fpdc_pkg::result_t res_reg, res_next;

    // quotient fits 17 bits: the average lies between the output centres
    for (genvar s = 0; s < fpdc_pkg::Q_BITS; s++)
    begin : g_step
        logic           v_in;
        fpdc_pkg::avg_t a_in;
        logic [19:0]    rem_in;
        logic [16:0]    q_in;
        logic [20:0]    t;
        logic           ge;

        if (s == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign a_in   = avg;
            assign rem_in = avg.mag[36:17];
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign v_in   = v_reg[s-1];
            assign a_in   = a_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        assign t  = {rem_in, a_in.mag[fpdc_pkg::Q_BITS-1-s]};
        assign ge = t >= {1'b0, a_in.den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[s]   <= a_in;
                rem_reg[s] <= ge ? 20'(t - {1'b0, a_in.den}) : t[19:0];
                q_reg[s]   <= {q_in[15:0], ge};
            end
        end
    end

    always_comb
    begin
        logic [16:0]    q;
        fpdc_pkg::avg_t a;
        logic [16:0]    nq;
        q  = q_reg[fpdc_pkg::Q_BITS-1];
        a  = a_reg[fpdc_pkg::Q_BITS-1];
        nq = 17'(-q);
        res_next.no_rule_fired = a.zero;
        if (a.zero)
            res_next.correction = '0;
        else if (a.neg)
            res_next.correction = (q > fpdc_pkg::SAT_NEG) ? 16'sh8000 : $signed(nq[15:0]);
        else
            res_next.correction = (q > fpdc_pkg::SAT_POS) ? 16'sh7fff : $signed(q[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v_reg[fpdc_pkg::Q_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign out_valid = vo_reg;
    assign result    = res_reg;

endmodule
`default_nettype wire

// ===== src/fuzzy_pd_controller_triangular_top.sv =====
// Throughput: one sample per cycle while the skid entry is empty; the 16-step membership
// divider and the 17-step averaging divider are fully pipelined, one quotient bit per stage.
// A two-entry output (register plus skid) lets the pipeline run while a result waits.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the registers to
// centre 0, spacing 5120, half width 5120.
`default_nettype none
module fuzzy_pd_controller_triangular_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire fpdc_pkg::sample_t sample,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output fpdc_pkg::result_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);

    fpdc_pkg::cfg_t      cfg_reg;
    logic                en;

    logic                fz_valid;
    fpdc_pkg::lane_vec_t rest;
    logic                md_valid;
    fpdc_pkg::lane_vec_t mu;
    logic                ru_valid;
    fpdc_pkg::avg_t      avg;
    logic                pipe_valid;
    fpdc_pkg::result_t   pipe_result;

    logic                result_valid_reg;
    fpdc_pkg::result_t   result_reg;
    logic                skid_valid_reg;
    fpdc_pkg::result_t   skid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.centre     <= '0;
            cfg_reg.spacing    <= fpdc_pkg::SPACING_RESET;
            cfg_reg.half_width <= fpdc_pkg::HALF_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fpdc_pkg::REG_CENTRE:     cfg_reg.centre     <= $signed(cfg_data);
                fpdc_pkg::REG_SPACING:    cfg_reg.spacing    <= cfg_data[14:0];
                fpdc_pkg::REG_HALF_WIDTH: cfg_reg.half_width <= cfg_data[14:0];
                default:                  ;
            endcase
        end
    end

    // the whole pipeline holds only while the skid entry is occupied
    assign en           = !skid_valid_reg;
    assign sample_stall = skid_valid_reg;

    fpdc_fuzz u_fuzz (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (sample_valid),
        .in_item   (sample),
        .out_valid (fz_valid),
        .rest      (rest)
    );

    fpdc_mdiv u_mdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (fz_valid),
        .rest      (rest),
        .out_valid (md_valid),
        .mu        (mu)
    );

    fpdc_rules u_rules (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (md_valid),
        .mu        (mu),
        .out_valid (ru_valid),
        .avg       (avg)
    );

    fpdc_adiv u_adiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ru_valid),
        .avg       (avg),
        .out_valid (pipe_valid),
        .result    (pipe_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (!result_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                result_valid_reg <= 1'b1;
                skid_valid_reg   <= 1'b0;
            end
            else
                result_valid_reg <= pipe_valid;
        end
        else if (pipe_valid && en)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
                result_reg <= skid_reg;
            else
                result_reg <= pipe_result;
        end
        else if (pipe_valid && en)
            skid_reg <= pipe_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

// ===== src/fpdc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module fpdc_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              sample_valid,
    input wire logic              sample_stall,
    input wire fpdc_pkg::sample_t sample,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire fpdc_pkg::result_t result,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready
);

    // an empty rule base gives a zero correction
    `ASSERT_IMPLIES(a_empty_gives_zero, clk, rst_n, result_valid && result.no_rule_fired, result.correction == 16'sd0)

    // input only backs up after a result was held at the output
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, sample_stall, $past(result_valid && result_stall))

    // a held result stays put
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

    // a stalled sample stays offered and unchanged
    `ASSERT_NEXT(a_sample_hold, clk, rst_n, sample_valid && sample_stall, sample_valid && $stable(sample))

    // register writes are never held off
    `ASSERT_IMPLIES(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind fuzzy_pd_controller_triangular_top fpdc_checker u_fpdc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
`default_nettype wire
